FILE: sv/psfd_pkg.sv
// shared types, constants and register indexes of the ppm-sum frame decoder
package psfd_pkg;

  localparam int unsigned MaxChannelsDefault = 16;

  localparam logic [1:0] RegSyncWidth   = 2'd0;
  localparam logic [1:0] RegMinValid    = 2'd1;
  localparam logic [1:0] RegMaxValid    = 2'd2;
  localparam logic [1:0] RegMinChannels = 2'd3;

  localparam logic [15:0] SyncWidthReset   = 16'd2700;
  localparam logic [15:0] MinValidReset    = 16'd700;
  localparam logic [15:0] MaxValidReset    = 16'd2300;
  localparam logic [4:0]  MinChannelsReset = 5'd5;

  typedef struct packed {
    logic [15:0] pulse_width;
  } pulse_t;

  typedef struct packed {
    logic [3:0]  channel_index;
    logic [15:0] channel_width;
    logic [4:0]  num_channels;
    logic [15:0] frame_number;
    logic        last_in_frame;
  } chan_t;

endpackage

FILE: sv/psfd_stream_if.sv
// valid/ready stream interface carrying one request payload
interface psfd_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: sv/psfd_ram.sv
// generic simple dual-port ram with registered read
module psfd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

FILE: sv/ppm_sum_frame_decoder.sv
// ppm-sum frame decoder top level: capture store ram, sync tracking, frame publishing
// a pulse is taken only while idle; a frame is published through the emit state, the ram read and the output register
// throughput: one pulse per cycle between frames; a frame of n channels is published with
// one ram read and one output register load per channel, with no pulse taken meanwhile
// reset: not synchronized, channel position and frame counter zero, registers at defaults
// the capture ram needs no clearing, only entries written since the last sync are read
module ppm_sum_frame_decoder #(
  parameter int unsigned MAX_CHANNELS = psfd_pkg::MaxChannelsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  psfd_stream_if.sink   pulse_i,
  psfd_stream_if.source chan_o
);
  localparam int unsigned PW = ($clog2(MAX_CHANNELS + 1) > 5) ? $clog2(MAX_CHANNELS + 1) : 5;
  localparam int unsigned AW = $clog2(MAX_CHANNELS);
  localparam int unsigned CW = (PW > 5) ? PW : 5;

  localparam logic StIdle = 1'b0;
  localparam logic StEmit = 1'b1;

  logic [15:0] sync_q, min_q, max_q;
  logic [4:0]  min_ch_q;

  logic          state_q, state_d;
  logic          in_sync_q, in_sync_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [PW-1:0] n_q, n_d;
  logic [15:0]   frame_q, frame_d;
  logic [PW-1:0] rd_idx_q, rd_idx_d;
  logic [PW-1:0] rd_k_q, rd_k_d;
  logic          pend_q, pend_d;
  logic          out_valid_q, out_valid_d;
  psfd_pkg::chan_t out_data_q;

  logic          accept, out_accept, issue, ram_we, is_sync, in_rng;
  logic [4:0]    need;
  logic [PW-1:0] pos_inc, pos_new;
  logic [15:0]   pw, rdata;

  assign pw         = pulse_i.data.pulse_width;
  assign accept     = pulse_i.valid && pulse_i.ready;
  assign out_accept = out_valid_q && chan_o.ready;
  assign need       = (min_ch_q == 5'd0) ? 5'd1 : min_ch_q;
  assign is_sync    = pw >= sync_q;
  assign in_rng     = (pw > min_q) && (pw < max_q) && (pos_q < PW'(MAX_CHANNELS));
  assign pos_inc    = pos_q + PW'(1);
  assign pos_new    = in_rng ? pos_inc : pos_q;
  assign issue      = (state_q == StEmit) && (rd_idx_q < n_q) && !pend_q
                      && (!out_valid_q || chan_o.ready);

  assign pulse_i.ready = (state_q == StIdle);
  assign chan_o.valid  = out_valid_q;
  assign chan_o.data   = out_data_q;

  always_comb begin
    state_d     = state_q;
    in_sync_d   = in_sync_q;
    pos_d       = pos_q;
    n_d         = n_q;
    frame_d     = frame_q;
    rd_idx_d    = rd_idx_q;
    rd_k_d      = rd_k_q;
    ram_we      = 1'b0;
    pend_d      = issue;
    out_valid_d = pend_q ? 1'b1 : (out_accept ? 1'b0 : out_valid_q);
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (is_sync) begin
            if (in_sync_q && (CW'(pos_q) >= CW'(need))) begin
              state_d  = StEmit;
              n_d      = pos_q;
              frame_d  = frame_q + 16'd1;
              rd_idx_d = '0;
            end
            pos_d     = '0;
            in_sync_d = 1'b1;
          end else if (in_sync_q) begin
            ram_we = in_rng;
            pos_d  = pos_new;
            if (pos_new >= PW'(MAX_CHANNELS)) begin
              state_d   = StEmit;
              n_d       = PW'(MAX_CHANNELS);
              frame_d   = frame_q + 16'd1;
              rd_idx_d  = '0;
              pos_d     = '0;
              in_sync_d = 1'b0;
            end
          end
        end
      end
      StEmit: begin
        if (issue) begin
          rd_idx_d = rd_idx_q + PW'(1);
          rd_k_d   = rd_idx_q;
        end
        if (out_accept && out_data_q.last_in_frame) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  psfd_ram #(
    .WIDTH(16),
    .DEPTH(MAX_CHANNELS)
  ) u_capture_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(pos_q[AW-1:0]),
    .wdata_i(pw),
    .re_i   (issue),
    .raddr_i(rd_idx_q[AW-1:0]),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q      <= psfd_pkg::SyncWidthReset;
      min_q       <= psfd_pkg::MinValidReset;
      max_q       <= psfd_pkg::MaxValidReset;
      min_ch_q    <= psfd_pkg::MinChannelsReset;
      state_q     <= StIdle;
      in_sync_q   <= 1'b0;
      pos_q       <= '0;
      n_q         <= '0;
      frame_q     <= '0;
      rd_idx_q    <= '0;
      rd_k_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          psfd_pkg::RegSyncWidth:   sync_q   <= cfg_data_i;
          psfd_pkg::RegMinValid:    min_q    <= cfg_data_i;
          psfd_pkg::RegMaxValid:    max_q    <= cfg_data_i;
          psfd_pkg::RegMinChannels: min_ch_q <= cfg_data_i[4:0];
          default: begin
          end
        endcase
      end
      state_q     <= state_d;
      in_sync_q   <= in_sync_d;
      pos_q       <= pos_d;
      n_q         <= n_d;
      frame_q     <= frame_d;
      rd_idx_q    <= rd_idx_d;
      rd_k_q      <= rd_k_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_q) begin
      out_data_q.channel_index <= rd_k_q[3:0];
      out_data_q.channel_width <= rdata;
      out_data_q.num_channels  <= n_q[4:0];
      out_data_q.frame_number  <= frame_q;
      out_data_q.last_in_frame <= ((rd_k_q + PW'(1)) == n_q);
    end
  end

  a_ready_not_while_emitting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pulse_i.ready |-> !chan_o.valid && !pend_q)
    else $error("pulse taken while a frame is being published");

  a_read_lands_in_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !out_valid_q)
    else $error("ram read returned while output register still full");

  a_position_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q < PW'(MAX_CHANNELS))
    else $error("channel position reached the channel maximum");

  a_last_index_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chan_o.valid && chan_o.data.last_in_frame |->
      chan_o.data.channel_index == 4'(chan_o.data.num_channels - 5'd1))
    else $error("last channel index does not match channel count");

  a_frame_counter_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) && (state_d == StEmit) |=> frame_q == $past(frame_q) + 16'd1)
    else $error("frame counter did not advance on publish");
endmodule
